>>> rtl/core/afn_pkg.sv
package afn_pkg;

	// fixed field widths
	localparam int NFEAT    = 8;
	localparam int FEAT_W   = 16;
	localparam int WORD_W   = 32;
	localparam int S_DATA_W = NFEAT * FEAT_W;
	localparam int M_DATA_W = 96;
	localparam int CFG_IW   = 4;

	// default matrix size
	localparam int DIM_DEF = 8;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_LR   = 4'd0;
	localparam logic [CFG_IW-1:0] REG_DIMS = 4'd1;

	// register reset values
	localparam logic [31:0] LR_RESET   = 32'd42950;
	localparam logic [3:0]  DIMS_RESET = 4'd8;

	// arithmetic constants
	localparam logic signed [31:0] ONE_Q24       = 32'sh0100_0000;
	localparam logic [30:0]        LN2_Q31       = 31'd1488522236;
	localparam logic signed [31:0] LOG_FLOOR_Q16 = -32'sd1358120;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_FBIAS, OP_RD, OP_FMUL, OP_FACC, OP_FZ, OP_FSQ,
		OP_SQACC, OP_LOGGO, OP_LOGACC, OP_ENERGY, OP_LD1, OP_LD2, OP_LD3, OP_NLL,
		OP_BMAG, OP_SC1, OP_SC2, OP_SC3, OP_SC4, OP_BAPPLY, OP_WGR, OP_GMAG,
		OP_WAPPLY, OP_DIVGO, OP_RECIP, OP_RAPPLY, OP_WWR, OP_OUT
	} op_t;

	// which step size scaling is in flight
	typedef enum logic [1:0] {
		K_BIAS, K_GRAD, K_REC
	} kind_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic diag_zero;
		logic a_zero;
		logic log_done;
		logic div_done;
		logic mode;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/afn_log.sv
module afn_log (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        m,
	output logic               done,
	output logic signed [31:0] res
);

	typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

	lstate_t     state_q;
	logic [31:0] t_q;
	logic [4:0]  p_q;
	logic [30:0] y_q;
	logic [23:0] fr_q;
	logic [4:0]  i_q;
	logic        done_q;
	logic [61:0] ysq;
	logic [31:0] yn;
	logic [7:0]  pe;

	// one squaring round
	assign ysq = y_q * y_q;
	assign yn  = ysq[61:30];

	// integer part is msb position minus 24
	assign pe   = {3'b000, p_q} - 8'd24;
	assign res  = $signed({pe, fr_q});
	assign done = done_q;

	// normalize one bit a cycle, then one squaring a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						t_q     <= m;
						p_q     <= 5'd31;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (!t_q[31] && p_q != 5'd0) begin
						t_q <= {t_q[30:0], 1'b0};
						p_q <= p_q - 5'd1;
					end else begin
						y_q     <= t_q[31:1];
						fr_q    <= '0;
						i_q     <= '0;
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					if (yn[31]) begin
						y_q  <= yn[31:1];
						fr_q <= {fr_q[22:0], 1'b1};
					end else begin
						y_q  <= yn[30:0];
						fr_q <= {fr_q[22:0], 1'b0};
					end
					i_q <= i_q + 5'd1;
					if (i_q == 5'd23) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/afn_div.sv
module afn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] m,
	output logic        done,
	output logic [48:0] q
);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t     state_q;
	logic [48:0] num_q;
	logic [48:0] q_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] rem2;
	logic [33:0] diff;

	// restoring step
	assign rem2 = {rem_q, num_q[48]};
	assign diff = {1'b0, rem2} - {2'b00, den_q};

	assign done = done_q;
	assign q    = q_q;

	// one quotient bit a cycle, dividend is 2^48 plus half the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						num_q   <= {1'b1, 17'b0, m[31:1]};
						den_q   <= m;
						rem_q   <= '0;
						q_q     <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					num_q <= {num_q[47:0], 1'b0};
					if (!diff[33]) begin
						rem_q <= diff[31:0];
						q_q   <= {q_q[47:0], 1'b1};
					end else begin
						rem_q <= rem2[31:0];
						q_q   <= {q_q[47:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd48) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/afn_dp.sv
module afn_dp #(
	parameter int DIM = afn_pkg::DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  afn_pkg::cmd_t                       cmd,
	input  logic [$clog2(DIM+1)-1:0]            r,
	input  logic [$clog2(DIM+1)-1:0]            c,
	input  logic [((DIM*(DIM+1)/2) > 1 ? $clog2(DIM*(DIM+1)/2) : 1)-1:0] addr,
	input  logic [31:0]                         lr,
	input  logic [afn_pkg::S_DATA_W-1:0]        in_data,
	input  logic                                in_mode,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [afn_pkg::M_DATA_W-1:0]        out_data,
	output logic                                out_sat,
	output afn_pkg::sts_t                       sts
);

	localparam int IW  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int TRI = DIM * (DIM + 1) / 2;

	// input item and stores
	logic signed [15:0] x_q [afn_pkg::NFEAT];
	logic               mode_q;
	logic signed [31:0] bias_q [DIM];
	logic signed [31:0] zr_q [DIM];
	logic signed [31:0] mem [TRI];
	logic [TRI-1:0]     wvld_q;
	logic signed [31:0] rd_q;
	logic               rvld_q;

	// forward pass
	logic signed [51:0] acc_q;
	logic signed [47:0] prod_s1;
	logic signed [31:0] diag_q;
	logic signed [31:0] zc_q;
	logic [63:0]        sqp_s1;
	logic [63:0]        sq_q;
	logic signed [35:0] logsum_q;
	logic               zdiag_q;
	logic signed [67:0] lp_q;
	logic [30:0]        energy_q;
	logic signed [31:0] logdet_q;
	logic signed [31:0] nll_q;
	logic               flag_q;

	// update pass
	logic [47:0]        mag_q;
	logic               neg_q;
	logic [55:0]        sp_s1;
	logic [79:0]        sacc_q;
	logic signed [57:0] sv_q;
	logic signed [31:0] a_q;
	logic signed [47:0] grad_s1;

	// output register
	logic                         oval_q;
	logic [afn_pkg::M_DATA_W-1:0] odata_q;
	logic                         osat_q;

	// shared units
	logic               log_start;
	logic               log_done;
	logic signed [31:0] log_res;
	logic               div_start;
	logic               div_done;
	logic [48:0]        div_q;

	logic signed [15:0] xs;
	logic signed [31:0] weff;
	logic signed [31:0] bias_r;
	logic signed [31:0] z_r;
	logic [31:0]        absz;
	logic [31:0]        absd;
	logic [31:0]        absa;
	logic signed [51:0] zsum;
	logic signed [31:0] zrnd;
	logic [63:0]        esum;
	logic [48:0]        ld_lo;
	logic signed [48:0] ld_hi;
	logic signed [67:0] ldsum;
	logic signed [31:0] ld32;
	logic signed [33:0] diff;
	logic [80:0]        ssum;
	logic [80:0]        half;
	logic [56:0]        rnd;
	logic signed [63:0] bsub;
	logic signed [63:0] asub;
	logic signed [63:0] aadd;
	logic [32:0]        bres;
	logic [32:0]        ares;
	logic [32:0]        nres;

	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] res;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			res = {1'b1, 32'h7FFF_FFFF};
		else if (v < 64'shFFFF_FFFF_8000_0000)
			res = {1'b1, 32'h8000_0000};
		else
			res = {1'b0, v[31:0]};
		return res;
	endfunction

	// feature for the current column, zero past the input vector
	always_comb begin
		xs = '0;
		for (int i = 0; i < afn_pkg::NFEAT; i++) begin
			if (int'(c) == i)
				xs = x_q[i];
		end
	end

	// unwritten weight reads as identity
	assign weff   = rvld_q ? rd_q : ((r == c) ? afn_pkg::ONE_Q24 : 32'sd0);
	assign bias_r = bias_q[r[IW-1:0]];
	assign z_r    = zr_q[r[IW-1:0]];
	assign absz   = z_r[31] ? (32'd0 - z_r) : z_r;
	assign absd   = diag_q[31] ? (32'd0 - diag_q) : diag_q;
	assign absa   = a_q[31] ? (32'd0 - a_q) : a_q;

	// z rounding, energy, log determinant
	assign zsum  = acc_q + 52'sd262144;
	assign zrnd  = zsum[50:19];
	assign esum  = sq_q + 64'h0000_0000_0001_0000;
	assign ld_lo = logsum_q[17:0] * afn_pkg::LN2_Q31;
	assign ld_hi = $signed(logsum_q[35:18]) * $signed({1'b0, afn_pkg::LN2_Q31});
	assign ldsum = lp_q + 68'sh0_0000_0040_0000_0000;
	assign ld32  = {{3{ldsum[67]}}, ldsum[67:39]};
	assign diff  = $signed({3'b000, energy_q}) - $signed({{2{logdet_q[31]}}, logdet_q});
	assign nres  = sat32({{30{diff[33]}}, diff});

	// step size scaling: round half up by the shift of the current kind
	always_comb begin
		unique case (cmd.kind)
			afn_pkg::K_GRAD: half = 81'h1 << 34;
			afn_pkg::K_REC:  half = 81'h1 << 31;
			default:         half = 81'h1 << 23;
		endcase
		ssum = {1'b0, sacc_q} + half;
		unique case (cmd.kind)
			afn_pkg::K_GRAD: rnd = {11'b0, ssum[80:35]};
			afn_pkg::K_REC:  rnd = {8'b0, ssum[80:32]};
			default:         rnd = ssum[80:24];
		endcase
	end

	// weight and bias results
	assign bsub = {{32{bias_r[31]}}, bias_r} - {{6{sv_q[57]}}, sv_q};
	assign asub = {{32{a_q[31]}}, a_q} - {{6{sv_q[57]}}, sv_q};
	assign aadd = {{32{a_q[31]}}, a_q} + {{6{sv_q[57]}}, sv_q};
	assign bres = sat32(bsub);
	assign ares = sat32((cmd.op == afn_pkg::OP_RAPPLY) ? aadd : asub);

	assign log_start = (cmd.op == afn_pkg::OP_LOGGO);
	assign div_start = (cmd.op == afn_pkg::OP_DIVGO) && (a_q != 32'sd0);

	afn_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.m      (absd),
		.done   (log_done),
		.res    (log_res)
	);

	afn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.m      (absa),
		.done   (div_done),
		.q      (div_q)
	);

	// weight memory
	always_ff @(posedge clk) begin
		if (cmd.op == afn_pkg::OP_WWR)
			mem[addr] <= a_q;
		if (cmd.op == afn_pkg::OP_RD) begin
			rd_q   <= mem[addr];
			rvld_q <= wvld_q[addr];
		end
	end

	// state with reset values: valid bits, bias, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
			oval_q <= 1'b0;
			for (int i = 0; i < DIM; i++)
				bias_q[i] <= '0;
		end else begin
			if (cmd.op == afn_pkg::OP_WWR)
				wvld_q[addr] <= 1'b1;
			if (cmd.op == afn_pkg::OP_BAPPLY)
				bias_q[r[IW-1:0]] <= bres[31:0];
			if (cmd.op == afn_pkg::OP_OUT)
				oval_q <= 1'b1;
			else if (out_ready)
				oval_q <= 1'b0;
		end
	end

	// datapath operations
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			afn_pkg::OP_LOAD: begin
				for (int i = 0; i < afn_pkg::NFEAT; i++)
					x_q[i] <= in_data[afn_pkg::FEAT_W*i +: afn_pkg::FEAT_W];
				mode_q   <= in_mode;
				sq_q     <= '0;
				logsum_q <= '0;
				zdiag_q  <= 1'b0;
				flag_q   <= 1'b0;
			end
			afn_pkg::OP_FBIAS: acc_q <= {{9{bias_r[31]}}, bias_r, 11'b0};
			afn_pkg::OP_FMUL: begin
				prod_s1 <= weff * xs;
				if (r == c)
					diag_q <= weff;
			end
			afn_pkg::OP_FACC: acc_q <= acc_q + {{4{prod_s1[47]}}, prod_s1};
			afn_pkg::OP_FZ: begin
				zc_q             <= zrnd;
				zr_q[r[IW-1:0]]  <= zrnd;
			end
			afn_pkg::OP_FSQ: sqp_s1 <= zc_q * zc_q;
			afn_pkg::OP_SQACC: begin
				sq_q <= sq_q + sqp_s1;
				if (diag_q == 32'sd0)
					zdiag_q <= 1'b1;
			end
			afn_pkg::OP_LOGACC: logsum_q <= logsum_q + {{4{log_res[31]}}, log_res};
			afn_pkg::OP_ENERGY: begin
				if (|esum[63:48]) begin
					energy_q <= 31'h7FFF_FFFF;
					flag_q   <= 1'b1;
				end else begin
					energy_q <= esum[47:17];
				end
			end
			afn_pkg::OP_LD1: lp_q <= {19'b0, ld_lo};
			afn_pkg::OP_LD2: lp_q <= lp_q + {ld_hi[48], ld_hi, 18'b0};
			afn_pkg::OP_LD3: begin
				if (zdiag_q || ld32 < afn_pkg::LOG_FLOOR_Q16)
					logdet_q <= afn_pkg::LOG_FLOOR_Q16;
				else
					logdet_q <= ld32;
			end
			afn_pkg::OP_NLL: begin
				nll_q <= nres[31:0];
				if (nres[32])
					flag_q <= 1'b1;
			end
			afn_pkg::OP_BMAG: begin
				mag_q <= {16'b0, absz};
				neg_q <= z_r[31];
			end
			afn_pkg::OP_SC1: sp_s1 <= lr * mag_q[23:0];
			afn_pkg::OP_SC2: begin
				sacc_q <= {24'b0, sp_s1};
				sp_s1  <= lr * mag_q[47:24];
			end
			afn_pkg::OP_SC3: sacc_q <= sacc_q + {sp_s1, 24'b0};
			afn_pkg::OP_SC4: sv_q <= neg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
			afn_pkg::OP_BAPPLY: begin
				if (bres[32])
					flag_q <= 1'b1;
			end
			afn_pkg::OP_WGR: begin
				a_q     <= weff;
				grad_s1 <= z_r * xs;
			end
			afn_pkg::OP_GMAG: begin
				mag_q <= grad_s1[47] ? (48'd0 - grad_s1) : grad_s1;
				neg_q <= grad_s1[47];
			end
			afn_pkg::OP_WAPPLY, afn_pkg::OP_RAPPLY: begin
				a_q <= ares[31:0];
				if (ares[32])
					flag_q <= 1'b1;
			end
			afn_pkg::OP_DIVGO: begin
				if (a_q == 32'sd0) begin
					mag_q  <= 48'h0000_7FFF_FFFF;
					neg_q  <= 1'b0;
					flag_q <= 1'b1;
				end
			end
			afn_pkg::OP_RECIP: begin
				neg_q <= a_q[31];
				if (|div_q[48:31]) begin
					mag_q  <= 48'h0000_7FFF_FFFF;
					flag_q <= 1'b1;
				end else begin
					mag_q <= {17'b0, div_q[30:0]};
				end
			end
			afn_pkg::OP_OUT: begin
				odata_q <= {1'b0, logdet_q, energy_q, nll_q};
				osat_q  <= flag_q;
			end
			default: ;
		endcase
	end

	assign out_valid = oval_q;
	assign out_data  = odata_q;
	assign out_sat   = osat_q;

	assign sts.diag_zero = (diag_q == 32'sd0);
	assign sts.a_zero    = (a_q == 32'sd0);
	assign sts.log_done  = log_done;
	assign sts.div_done  = div_done;
	assign sts.mode      = mode_q;
	assign sts.out_free  = !oval_q || out_ready;

endmodule

>>> rtl/core/afn_ctrl.sv
module afn_ctrl #(
	parameter int DIM = afn_pkg::DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                dims,
	input  afn_pkg::sts_t             sts,
	output afn_pkg::cmd_t             cmd,
	output logic [$clog2(DIM+1)-1:0]  r,
	output logic [$clog2(DIM+1)-1:0]  c,
	output logic [((DIM*(DIM+1)/2) > 1 ? $clog2(DIM*(DIM+1)/2) : 1)-1:0] addr
);

	localparam int CW  = $clog2(DIM + 1);
	localparam int TRI = DIM * (DIM + 1) / 2;
	localparam int AW  = (TRI > 1) ? $clog2(TRI) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_FBIAS, S_FRD, S_FMUL, S_FACC, S_FZ, S_FSQ, S_SQACC, S_LOGGO,
		S_LOGW, S_EN, S_LD1, S_LD2, S_LD3, S_NLL, S_BMAG, S_SC1, S_SC2, S_SC3,
		S_SC4, S_BAPPLY, S_WRD, S_WGR, S_GMAG, S_WAPPLY, S_DIVGO, S_DIVW,
		S_RAPPLY, S_WWR, S_DONE
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          r_q;
	logic [CW-1:0]          c_q;
	logic [CW-1:0]          n_q;
	logic [AW-1:0]          base_q;
	afn_pkg::kind_t         kind_q;
	logic                   last_c;
	logic                   last_r;
	logic [AW-1:0]          next_base;
	logic                   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_c    = (c_q == r_q);
	assign last_r    = ((r_q + CW'(1)) == n_q);
	assign next_base = base_q + AW'(r_q) + AW'(1);
	assign addr      = base_q + AW'(c_q);
	assign r         = r_q;
	assign c         = c_q;

	// command decode
	always_comb begin
		cmd.kind = kind_q;
		unique case (state_q)
			S_IDLE:   cmd.op = accept ? afn_pkg::OP_LOAD : afn_pkg::OP_NONE;
			S_FBIAS:  cmd.op = afn_pkg::OP_FBIAS;
			S_FRD:    cmd.op = afn_pkg::OP_RD;
			S_FMUL:   cmd.op = afn_pkg::OP_FMUL;
			S_FACC:   cmd.op = afn_pkg::OP_FACC;
			S_FZ:     cmd.op = afn_pkg::OP_FZ;
			S_FSQ:    cmd.op = afn_pkg::OP_FSQ;
			S_SQACC:  cmd.op = afn_pkg::OP_SQACC;
			S_LOGGO:  cmd.op = afn_pkg::OP_LOGGO;
			S_LOGW:   cmd.op = sts.log_done ? afn_pkg::OP_LOGACC : afn_pkg::OP_NONE;
			S_EN:     cmd.op = afn_pkg::OP_ENERGY;
			S_LD1:    cmd.op = afn_pkg::OP_LD1;
			S_LD2:    cmd.op = afn_pkg::OP_LD2;
			S_LD3:    cmd.op = afn_pkg::OP_LD3;
			S_NLL:    cmd.op = afn_pkg::OP_NLL;
			S_BMAG:   cmd.op = afn_pkg::OP_BMAG;
			S_SC1:    cmd.op = afn_pkg::OP_SC1;
			S_SC2:    cmd.op = afn_pkg::OP_SC2;
			S_SC3:    cmd.op = afn_pkg::OP_SC3;
			S_SC4:    cmd.op = afn_pkg::OP_SC4;
			S_BAPPLY: cmd.op = afn_pkg::OP_BAPPLY;
			S_WRD:    cmd.op = afn_pkg::OP_RD;
			S_WGR:    cmd.op = afn_pkg::OP_WGR;
			S_GMAG:   cmd.op = afn_pkg::OP_GMAG;
			S_WAPPLY: cmd.op = afn_pkg::OP_WAPPLY;
			S_DIVGO:  cmd.op = afn_pkg::OP_DIVGO;
			S_DIVW:   cmd.op = sts.div_done ? afn_pkg::OP_RECIP : afn_pkg::OP_NONE;
			S_RAPPLY: cmd.op = afn_pkg::OP_RAPPLY;
			S_WWR:    cmd.op = afn_pkg::OP_WWR;
			S_DONE:   cmd.op = sts.out_free ? afn_pkg::OP_OUT : afn_pkg::OP_NONE;
			default:  cmd.op = afn_pkg::OP_NONE;
		endcase
	end

	// sequencer: forward rows, then bias and weight updates when mode is set, then the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			n_q     <= '0;
			base_q  <= '0;
			kind_q  <= afn_pkg::K_BIAS;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (dims == 4'd0)
							n_q <= CW'(1);
						else if (int'(dims) > DIM)
							n_q <= CW'(DIM);
						else
							n_q <= CW'(dims);
						r_q     <= '0;
						base_q  <= '0;
						state_q <= S_FBIAS;
					end
				end
				S_FBIAS: begin
					c_q     <= '0;
					state_q <= S_FRD;
				end
				S_FRD:  state_q <= S_FMUL;
				S_FMUL: state_q <= S_FACC;
				S_FACC: begin
					if (last_c) begin
						state_q <= S_FZ;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_FRD;
					end
				end
				S_FZ:  state_q <= S_FSQ;
				S_FSQ: state_q <= S_SQACC;
				S_SQACC, S_LOGW: begin
					if (state_q == S_SQACC && !sts.diag_zero) begin
						state_q <= S_LOGGO;
					end else if (state_q == S_SQACC || sts.log_done) begin
						if (last_r) begin
							state_q <= S_EN;
						end else begin
							r_q     <= r_q + CW'(1);
							base_q  <= next_base;
							state_q <= S_FBIAS;
						end
					end
				end
				S_LOGGO: state_q <= S_LOGW;
				S_EN:    state_q <= S_LD1;
				S_LD1:   state_q <= S_LD2;
				S_LD2:   state_q <= S_LD3;
				S_LD3:   state_q <= S_NLL;
				S_NLL: begin
					r_q     <= '0;
					state_q <= sts.mode ? S_BMAG : S_DONE;
				end
				S_BMAG: begin
					kind_q  <= afn_pkg::K_BIAS;
					state_q <= S_SC1;
				end
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_SC3;
				S_SC3: state_q <= S_SC4;
				S_SC4: begin
					unique case (kind_q)
						afn_pkg::K_GRAD: state_q <= S_WAPPLY;
						afn_pkg::K_REC:  state_q <= S_RAPPLY;
						default:         state_q <= S_BAPPLY;
					endcase
				end
				S_BAPPLY: begin
					if (last_r) begin
						r_q     <= '0;
						c_q     <= '0;
						base_q  <= '0;
						state_q <= S_WRD;
					end else begin
						r_q     <= r_q + CW'(1);
						state_q <= S_BMAG;
					end
				end
				S_WRD: state_q <= S_WGR;
				S_WGR: state_q <= S_GMAG;
				S_GMAG: begin
					kind_q  <= afn_pkg::K_GRAD;
					state_q <= S_SC1;
				end
				S_WAPPLY: state_q <= last_c ? S_DIVGO : S_WWR;
				S_DIVGO: begin
					kind_q  <= afn_pkg::K_REC;
					state_q <= sts.a_zero ? S_SC1 : S_DIVW;
				end
				S_DIVW: begin
					if (sts.div_done)
						state_q <= S_SC1;
				end
				S_RAPPLY: state_q <= S_WWR;
				S_WWR: begin
					if (!last_c) begin
						c_q     <= c_q + CW'(1);
						state_q <= S_WRD;
					end else if (last_r) begin
						state_q <= S_DONE;
					end else begin
						r_q     <= r_q + CW'(1);
						c_q     <= '0;
						base_q  <= next_base;
						state_q <= S_WRD;
					end
				end
				S_DONE: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/affine_flow_nll_sgd_engine_top.sv
// channel    direction  handshake                    payload
// s_axis     in         s_axis_tvalid/s_axis_tready  tdata features, tuser mode
// m_axis     out        m_axis_tvalid/m_axis_tready  tdata nll/energy/log det, tuser saturated
// cfg        in         cfg_we                       cfg_index, cfg_data
//
// one item at a time; with n active dimensions scoring runs one pass per row, set by the
// log unit, which runs once per nonzero diagonal entry; an update runs per bias and per
// weight, with the radix-2 reciprocal divider for each nonzero diagonal entry.
// the next item is taken once the previous result sits in the output register.
// arst_n clears control state and bias, and marks every weight as unwritten (identity).
module affine_flow_nll_sgd_engine_top #(
	parameter int DIM = afn_pkg::DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// feature_0 .. feature_7, 16 bits each
	input  logic [afn_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// loss [31:0], energy_term [62:32], log_det_term [94:63], zero fill
	output logic [afn_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// saturated
	output logic                          m_axis_tuser,
	input  logic                          cfg_we,
	input  logic [afn_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int CW  = $clog2(DIM + 1);
	localparam int TRI = DIM * (DIM + 1) / 2;
	localparam int AW  = (TRI > 1) ? $clog2(TRI) : 1;

	logic [31:0]   lr_q;
	logic [3:0]    dims_q;
	afn_pkg::cmd_t cmd;
	afn_pkg::sts_t sts;
	logic [CW-1:0] r;
	logic [CW-1:0] c;
	logic [AW-1:0] addr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= afn_pkg::LR_RESET;
			dims_q <= afn_pkg::DIMS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == afn_pkg::REG_LR)
				lr_q <= cfg_data;
			else if (cfg_index == afn_pkg::REG_DIMS)
				dims_q <= cfg_data[3:0];
		end
	end

	afn_ctrl #(.DIM(DIM)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.dims     (dims_q),
		.sts      (sts),
		.cmd      (cmd),
		.r        (r),
		.c        (c),
		.addr     (addr)
	);

	afn_dp #(.DIM(DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.r         (r),
		.c         (c),
		.addr      (addr),
		.lr        (lr_q),
		.in_data   (s_axis_tdata),
		.in_mode   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_sat   (m_axis_tuser),
		.sts       (sts)
	);

endmodule

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [afn_pkg::CFG_IW-1:0] REG_SPARE = 4'd5;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 2000;

	typedef struct packed {
		logic signed [31:0] nll;
		logic [30:0]        energy;
		logic signed [31:0] log_det;
		logic               sat;
	} score_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [afn_pkg::S_DATA_W-1:0] s_axis_tdata;
	logic                         s_axis_tuser;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [afn_pkg::M_DATA_W-1:0] m_axis_tdata;
	logic                         m_axis_tuser;
	logic                         cfg_we;
	logic [afn_pkg::CFG_IW-1:0]   cfg_index;
	logic [31:0]                  cfg_data;

	// model state of the flow
	int          weights [36];
	int          biases [8];
	logic [31:0] step_size;
	logic [3:0]  dims_reg;
	bit          clip_seen;

	score_t score_q [$];
	int     mismatches;
	bit     idle_en;
	int     stall_left;
	int     quiet_cycles;

	affine_flow_nll_sgd_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clip to signed word range, note any clip
	function automatic int clip_word(longint v);
		if (v > 64'sd2147483647) begin
			clip_seen = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			clip_seen = 1'b1;
			return 32'sh80000000;
		end
		return int'(v);
	endfunction

	// step size times signed value, rounded half up on the magnitude
	function automatic longint scale_by_rate(logic [31:0] lr, longint g, int sh);
		longint unsigned mag, hi, lo, t, s;
		mag = (g < 0) ? longint'(-g) : longint'(g);
		hi = mag * longint'(lr[31:16]);
		lo = mag * longint'(lr[15:0]);
		t = lo + (64'd1 << (sh - 1));
		s = (hi + (t >> 16)) >> (sh - 16);
		return (g < 0) ? -longint'(s) : longint'(s);
	endfunction

	// log2 of a Q8.24 magnitude by repeated squaring
	function automatic longint log2_fixed(longint unsigned m);
		int p;
		longint unsigned y;
		longint fr;
		p = 31;
		fr = 0;
		while (p > 0 && m[p] == 1'b0)
			p--;
		y = (p <= 30) ? (m << (30 - p)) : (m >> 1);
		for (int i = 0; i < 24; i++) begin
			y = (y * y) >> 30;
			fr = fr << 1;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				fr = fr | 1;
			end
		end
		return longint'(p - 24) * 16777216 + fr;
	endfunction

	// score one feature vector, then take the sgd step when training
	function automatic score_t score_and_train(logic train, logic [afn_pkg::S_DATA_W-1:0] d);
		longint x [8];
		longint z [8];
		int n, k, a, dg;
		longint acc, energy, logsum, logdet, rec;
		longint unsigned sq, m, q;
		bit zero_diag;
		score_t res;
		n = (dims_reg < 1) ? 1 : (dims_reg > 8) ? 8 : int'(dims_reg);
		clip_seen = 1'b0;
		zero_diag = 1'b0;
		sq = 0;
		logsum = 0;
		for (int i = 0; i < 8; i++)
			x[i] = longint'($signed(d[16*i +: 16]));
		for (int r = 0; r < n; r++) begin
			acc = longint'(biases[r]) * 2048;
			for (int c = 0; c <= r; c++)
				acc += longint'(weights[r*(r+1)/2 + c]) * x[c];
			z[r] = (acc + (64'sd1 <<< 18)) >>> 19;
			m = (z[r] < 0) ? longint'(-z[r]) : longint'(z[r]);
			sq += m * m;
			dg = weights[r*(r+1)/2 + r];
			if (dg == 0)
				zero_diag = 1'b1;
			else
				logsum += log2_fixed((dg < 0) ? -longint'(dg) : longint'(dg));
		end
		energy = longint'((sq + (64'd1 << 16)) >> 17);
		if (energy > 64'sd2147483647) begin
			energy = 64'sd2147483647;
			clip_seen = 1'b1;
		end
		logdet = (logsum * longint'(afn_pkg::LN2_Q31) + (64'sd1 <<< 38)) >>> 39;
		if (zero_diag || logdet < longint'(afn_pkg::LOG_FLOOR_Q16))
			logdet = longint'(afn_pkg::LOG_FLOOR_Q16);
		res.nll = clip_word(energy - logdet);
		res.energy = energy[30:0];
		res.log_det = logdet[31:0];
		if (train) begin
			for (int r = 0; r < n; r++)
				biases[r] = clip_word(longint'(biases[r]) - scale_by_rate(step_size, z[r], 24));
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c <= r; c++) begin
					k = r*(r+1)/2 + c;
					a = clip_word(longint'(weights[k])
						- scale_by_rate(step_size, z[r] * x[c], 35));
					if (r == c) begin
						if (a == 0) begin
							rec = 64'sd2147483647;
							clip_seen = 1'b1;
						end else begin
							m = (a < 0) ? -longint'(a) : longint'(a);
							q = ((64'd1 << 48) + m / 2) / m;
							if (q > 64'd2147483647) begin
								q = 64'd2147483647;
								clip_seen = 1'b1;
							end
							rec = (a < 0) ? -longint'(q) : longint'(q);
						end
						a = clip_word(longint'(a) + scale_by_rate(step_size, rec, 32));
					end
					weights[k] = a;
				end
			end
		end
		res.sat = clip_seen;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// result checker
	always @(posedge clk) begin
		score_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (score_q.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 0);
			end else begin
				want = score_q.pop_front();
				if ($signed(m_axis_tdata[31:0]) != want.nll)
					report_mismatch("loss", $signed(m_axis_tdata[31:0]), want.nll);
				if (m_axis_tdata[62:32] != want.energy)
					report_mismatch("energy_term", m_axis_tdata[62:32], want.energy);
				if ($signed(m_axis_tdata[94:63]) != want.log_det)
					report_mismatch("log_det_term", $signed(m_axis_tdata[94:63]),
						want.log_det);
				if (m_axis_tdata[95] != 1'b0)
					report_mismatch("tdata fill", m_axis_tdata[95], 0);
				if (m_axis_tuser != want.sat)
					report_mismatch("saturated", m_axis_tuser, want.sat);
			end
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// send one feature vector, valid stays high unless a gap follows
	task automatic send_vector(logic train, logic [afn_pkg::S_DATA_W-1:0] d);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= train;
		do
			@(posedge clk);
		while (!s_axis_tready);
		score_q.push_back(score_and_train(train, d));
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (score_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [afn_pkg::CFG_IW-1:0] idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == afn_pkg::REG_LR)
			step_size = val;
		else if (idx == afn_pkg::REG_DIMS)
			dims_reg = val[3:0];
	endtask

	function automatic logic [afn_pkg::S_DATA_W-1:0] random_vector(int small_pct);
		logic [afn_pkg::S_DATA_W-1:0] d;
		for (int i = 0; i < 8; i++)
			d[16*i +: 16] = ($urandom_range(0, 99) < small_pct)
				? 16'($urandom_range(0, 4095) - 2048) : 16'($urandom);
		return d;
	endfunction

	function automatic logic [afn_pkg::S_DATA_W-1:0] fill_vector(logic [15:0] v);
		return {8{v}};
	endfunction

	// field extremes with identity weights, then training on moderate fills
	task automatic test_extremes();
		send_vector(1'b0, '0);
		send_vector(1'b0, fill_vector(16'h7fff));
		send_vector(1'b0, fill_vector(16'h8000));
		send_vector(1'b0, {4{16'h8000, 16'h7fff}});
		send_vector(1'b1, fill_vector(16'h0800));
		send_vector(1'b1, fill_vector(16'hf800));
		send_vector(1'b0, fill_vector(16'h0800));
		send_vector(1'b1, '0);
	endtask

	// out of range dimension, ignored register, zero diagonal via full step size
	task automatic test_special_cases();
		write_reg(afn_pkg::REG_DIMS, 32'd0);
		send_vector(1'b1, fill_vector(16'h0400));
		write_reg(afn_pkg::REG_DIMS, 32'd15);
		send_vector(1'b0, fill_vector(16'h0400));
		write_reg(REG_SPARE, 32'hffff_ffff);
		send_vector(1'b0, fill_vector(16'hfc00));
		write_reg(afn_pkg::REG_DIMS, 32'd1);
		write_reg(afn_pkg::REG_LR, 32'hffff_ffff);
		send_vector(1'b1, fill_vector(16'h0800));
		send_vector(1'b1, fill_vector(16'h0800));
		send_vector(1'b0, fill_vector(16'h7fff));
		send_vector(1'b1, fill_vector(16'h8000));
		send_vector(1'b0, '0);
		write_reg(afn_pkg::REG_LR, 32'd0);
		send_vector(1'b1, fill_vector(16'h1234));
	endtask

	// random traffic at one step size, dimension changing between chunks
	task automatic test_random_training(logic [31:0] lr, int count, int small_pct);
		write_reg(afn_pkg::REG_LR, lr);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				write_reg(afn_pkg::REG_DIMS,
					(i == 0) ? 32'd8 : 32'($urandom_range(1, 8)));
			send_vector(1'($urandom_range(0, 99) < 70), random_vector(small_pct));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		stall_left = 0;
		quiet_cycles = 0;
		idle_en = 1'b1;
		for (int r = 0; r < 8; r++) begin
			biases[r] = 0;
			for (int c = 0; c <= r; c++)
				weights[r*(r+1)/2 + c] = (r == c) ? afn_pkg::ONE_Q24 : 0;
		end
		step_size = afn_pkg::LR_RESET;
		dims_reg = afn_pkg::DIMS_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_cases();
		test_random_training(32'd42950, 320, 90);
		test_random_training(32'($urandom_range(1, 1 << 20)), 320, 80);
		test_random_training(32'd0, 200, 20);
		test_random_training(32'h0100_0000, 250, 85);
		test_random_training(32'hffff_ffff, 120, 50);
		idle_en = 1'b0;
		test_random_training(32'd42950, 420, 70);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

>>> files.f
rtl/core/afn_pkg.sv
rtl/core/afn_log.sv
rtl/core/afn_div.sv
rtl/core/afn_dp.sv
rtl/core/afn_ctrl.sv
rtl/core/affine_flow_nll_sgd_engine_top.sv
bench/tb.sv
